[hw/rtl/mau_pkg.sv]
// Shared types, constants and microcode ROM for the modular arithmetic unit.
package mau_pkg;

    localparam logic [29:0] P_MOD      = 30'd1000000007;
    localparam logic [31:0] TWO_P_MOD  = 32'd2000000014;
    localparam logic [30:0] BARRETT_M  = 31'd1152921496;  // floor(2^60 / p)
    localparam logic [62:0] FERMAT_EXP = 63'd1000000005;  // p - 2

    localparam int UPC_W = 5;
    typedef logic [UPC_W-1:0] upc_t;
    typedef logic [29:0] resid_t;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_POW = 3'd3,
        OP_DIV = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ACC_HOLD = 3'd0,
        ACC_ONE  = 3'd1,
        ACC_ZERO = 3'd2,
        ACC_ADD  = 3'd3,
        ACC_SUB  = 3'd4
    } acc_op_t;

    typedef enum logic [2:0] {
        MUL_NONE      = 3'd0,
        MUL_A_B       = 3'd1,
        MUL_ACC_BASE  = 3'd2,
        MUL_BASE_BASE = 3'd3,
        MUL_A_ACC     = 3'd4
    } mul_sel_t;

    typedef enum logic [1:0] {
        MD_NONE = 2'd0,
        MD_ACC  = 2'd1,
        MD_BASE = 2'd2
    } mul_dst_t;

    typedef enum logic [2:0] {
        J_NEXT     = 3'd0,
        J_ALWAYS   = 3'd1,
        J_DISPATCH = 3'd2,
        J_EXP_ZERO = 3'd3,
        J_BIT_CLR  = 3'd4,
        J_IS_POW   = 3'd5
    } jcond_t;

    // One control word per microcode step
    typedef struct packed {
        acc_op_t  acc_op;
        logic     base_from_a;
        logic     exp_fermat;
        logic     exp_shift;
        mul_sel_t mul_sel;
        mul_dst_t mul_dst;
        jcond_t   jcond;
        logic     done;
        upc_t     target;
    } uword_t;

    // Datapath status seen by the sequencer
    typedef struct packed {
        logic exp_zero;
        logic exp_bit0;
    } dp_stat_t;

    localparam uword_t UW_NOP = '{
        acc_op:      ACC_HOLD,
        base_from_a: 1'b0,
        exp_fermat:  1'b0,
        exp_shift:   1'b0,
        mul_sel:     MUL_NONE,
        mul_dst:     MD_NONE,
        jcond:       J_NEXT,
        done:        1'b0,
        target:      '0
    };

    // Microcode addresses
    localparam upc_t A_DISP  = 5'd0;
    localparam upc_t A_ADD   = 5'd1;
    localparam upc_t A_SUB   = 5'd2;
    localparam upc_t A_MUL   = 5'd3;
    localparam upc_t A_MULW  = 5'd4;
    localparam upc_t A_POW   = 5'd5;
    localparam upc_t A_DIV   = 5'd6;
    localparam upc_t A_LOOP  = 5'd7;
    localparam upc_t A_BIT   = 5'd8;
    localparam upc_t A_ACCM  = 5'd9;
    localparam upc_t A_ACCW  = 5'd10;
    localparam upc_t A_SQ    = 5'd11;
    localparam upc_t A_SQW   = 5'd12;
    localparam upc_t A_FIN   = 5'd13;
    localparam upc_t A_QM    = 5'd14;
    localparam upc_t A_QW    = 5'd15;
    localparam upc_t A_OUT   = 5'd16;
    localparam upc_t A_ZERO  = 5'd17;

    function automatic uword_t ucode_rom(upc_t addr);
        uword_t w;
        w = UW_NOP;
        case (addr)
            A_DISP:  w.jcond = J_DISPATCH;
            A_ADD:
            begin
                w.acc_op = ACC_ADD;
                w.jcond  = J_ALWAYS;
                w.target = A_OUT;
            end
            A_SUB:
            begin
                w.acc_op = ACC_SUB;
                w.jcond  = J_ALWAYS;
                w.target = A_OUT;
            end
            A_MUL:   w.mul_sel = MUL_A_B;
            A_MULW:
            begin
                w.mul_dst = MD_ACC;
                w.jcond   = J_ALWAYS;
                w.target  = A_OUT;
            end
            A_POW:
            begin
                w.base_from_a = 1'b1;
                w.acc_op      = ACC_ONE;
                w.jcond       = J_ALWAYS;
                w.target      = A_LOOP;
            end
            A_DIV:
            begin
                w.acc_op     = ACC_ONE;
                w.exp_fermat = 1'b1;
            end
            A_LOOP:
            begin
                w.jcond  = J_EXP_ZERO;
                w.target = A_FIN;
            end
            A_BIT:
            begin
                w.jcond  = J_BIT_CLR;
                w.target = A_SQ;
            end
            A_ACCM:  w.mul_sel = MUL_ACC_BASE;
            A_ACCW:  w.mul_dst = MD_ACC;
            A_SQ:    w.mul_sel = MUL_BASE_BASE;
            A_SQW:
            begin
                w.mul_dst   = MD_BASE;
                w.exp_shift = 1'b1;
                w.jcond     = J_ALWAYS;
                w.target    = A_LOOP;
            end
            A_FIN:
            begin
                w.jcond  = J_IS_POW;
                w.target = A_OUT;
            end
            A_QM:    w.mul_sel = MUL_A_ACC;
            A_QW:    w.mul_dst = MD_ACC;
            A_OUT:   w.done = 1'b1;
            A_ZERO:
            begin
                w.acc_op = ACC_ZERO;
                w.jcond  = J_ALWAYS;
                w.target = A_OUT;
            end
            default: w = UW_NOP;
        endcase
        return w;
    endfunction

    function automatic upc_t dispatch(logic [2:0] op);
        upc_t t;
        case (op)
            OP_ADD:  t = A_ADD;
            OP_SUB:  t = A_SUB;
            OP_MUL:  t = A_MUL;
            OP_POW:  t = A_POW;
            OP_DIV:  t = A_DIV;
            default: t = A_ZERO;
        endcase
        return t;
    endfunction

    function automatic resid_t reduce_once(logic [29:0] v);
        return (v >= P_MOD) ? resid_t'(v - P_MOD) : v;
    endfunction

endpackage

[hw/rtl/mau_modmul.sv]
// Six-stage pipelined Barrett multiplier modulo p; a new product may start while earlier ones are in the stages.
module mau_modmul
    import mau_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   start,
    input  resid_t x,
    input  resid_t y,
    output logic   done,
    output resid_t res
);

    logic [5:0]  vld_reg;
    logic [59:0] prod_reg;
    logic [61:0] t_reg;
    logic [33:0] xlo1_reg;
    logic [33:0] xlo2_reg;
    logic [33:0] qp_reg;
    logic [31:0] r_reg;
    logic [31:0] r1_reg;
    resid_t      res_reg;

    logic [59:0] prod_w;
    logic [61:0] t_w;
    logic [33:0] qp_w;
    logic [33:0] diff_w;

    assign prod_w = {30'd0, x} * {30'd0, y};
    assign t_w    = {31'd0, prod_reg[59:29]} * {31'd0, BARRETT_M};
    assign qp_w   = {3'd0, t_reg[61:31]} * {4'd0, P_MOD};
    assign diff_w = xlo2_reg - qp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[4:0], start};
        end
    end

    // Quotient estimate is short by at most two, so the remainder stays below 3p
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_w;
        t_reg    <= t_w;
        xlo1_reg <= prod_reg[33:0];
        xlo2_reg <= xlo1_reg;
        qp_reg   <= qp_w;
        r_reg    <= diff_w[31:0];
        r1_reg   <= (r_reg >= TWO_P_MOD) ? (r_reg - TWO_P_MOD) : r_reg;
        res_reg  <= (r1_reg >= {2'b00, P_MOD}) ? resid_t'(r1_reg - {2'b00, P_MOD})
                                                : r1_reg[29:0];
    end

    assign done = vld_reg[5];
    assign res  = res_reg;

endmodule

[hw/rtl/mau_dp.sv]
// Operand, accumulator and exponent registers with the add/subtract path.
module mau_dp
    import mau_pkg::*;
(
    input  logic        clk,
    input  logic        load,
    input  logic [29:0] a_in,
    input  logic [29:0] b_in,
    input  logic [62:0] e_in,
    input  uword_t      ctl,
    input  resid_t      mul_res,
    output dp_stat_t    stat,
    output logic        mul_start,
    output resid_t      mul_x,
    output resid_t      mul_y,
    output resid_t      acc
);

    resid_t      opa_reg, opa_next;
    resid_t      base_reg, base_next;
    resid_t      acc_reg, acc_next;
    logic [62:0] exp_reg, exp_next;

    logic [30:0] sum_w;
    logic [30:0] diff_w;
    resid_t      sum_red;
    resid_t      diff_red;

    always_comb
    begin
        sum_w    = {1'b0, opa_reg} + {1'b0, base_reg};
        diff_w   = {1'b0, opa_reg} + {1'b0, P_MOD} - {1'b0, base_reg};
        sum_red  = (sum_w >= {1'b0, P_MOD}) ? resid_t'(sum_w - {1'b0, P_MOD})
                                            : sum_w[29:0];
        diff_red = (diff_w >= {1'b0, P_MOD}) ? resid_t'(diff_w - {1'b0, P_MOD})
                                             : diff_w[29:0];
    end

    always_comb
    begin
        mul_start = (ctl.mul_sel != MUL_NONE);
        case (ctl.mul_sel)
            MUL_A_B:
            begin
                mul_x = opa_reg;
                mul_y = base_reg;
            end
            MUL_ACC_BASE:
            begin
                mul_x = acc_reg;
                mul_y = base_reg;
            end
            MUL_BASE_BASE:
            begin
                mul_x = base_reg;
                mul_y = base_reg;
            end
            MUL_A_ACC:
            begin
                mul_x = opa_reg;
                mul_y = acc_reg;
            end
            default:
            begin
                mul_x = acc_reg;
                mul_y = base_reg;
            end
        endcase
    end

    always_comb
    begin
        opa_next  = opa_reg;
        base_next = base_reg;
        acc_next  = acc_reg;
        exp_next  = exp_reg;
        if (load)
        begin
            opa_next  = reduce_once(a_in);
            base_next = reduce_once(b_in);
            exp_next  = e_in;
        end
        else
        begin
            case (ctl.acc_op)
                ACC_ONE:  acc_next = 30'd1;
                ACC_ZERO: acc_next = '0;
                ACC_ADD:  acc_next = sum_red;
                ACC_SUB:  acc_next = diff_red;
                default:  acc_next = acc_reg;
            endcase
            if (ctl.mul_dst == MD_ACC)
            begin
                acc_next = mul_res;
            end
            if (ctl.base_from_a)
            begin
                base_next = opa_reg;
            end
            if (ctl.mul_dst == MD_BASE)
            begin
                base_next = mul_res;
            end
            if (ctl.exp_fermat)
            begin
                exp_next = FERMAT_EXP;
            end
            if (ctl.exp_shift)
            begin
                exp_next = {1'b0, exp_reg[62:1]};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        opa_reg  <= opa_next;
        base_reg <= base_next;
        acc_reg  <= acc_next;
        exp_reg  <= exp_next;
    end

    assign stat.exp_zero = (exp_reg == '0);
    assign stat.exp_bit0 = exp_reg[0];
    assign acc           = acc_reg;

endmodule

[hw/rtl/mau_seq.sv]
// Microcode sequencer: step counter, ROM fetch, stalls and conditional jumps.
module mau_seq
    import mau_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [2:0] op,
    input  dp_stat_t   stat,
    input  logic       mul_done,
    input  logic       out_free,
    output logic       busy,
    output uword_t     ctl,
    output logic       finish
);

    upc_t       pc_reg, pc_next;
    logic       busy_reg, busy_next;
    logic [2:0] op_reg, op_next;

    uword_t uw;
    logic   stall;
    logic   fire;
    logic   take;
    upc_t   jump_to;

    always_comb
    begin
        uw      = ucode_rom(pc_reg);
        // hold a wait step until the product lands, and the last step until output frees
        stall   = ((uw.mul_dst != MD_NONE) && !mul_done) || (uw.done && !out_free);
        fire    = busy_reg && !stall;
        jump_to = uw.target;
        case (uw.jcond)
            J_NEXT:     take = 1'b0;
            J_ALWAYS:   take = 1'b1;
            J_DISPATCH:
            begin
                take    = 1'b1;
                jump_to = dispatch(op_reg);
            end
            J_EXP_ZERO: take = stat.exp_zero;
            J_BIT_CLR:  take = !stat.exp_bit0;
            J_IS_POW:   take = (op_reg == OP_POW);
            default:    take = 1'b0;
        endcase
    end

    always_comb
    begin
        pc_next   = pc_reg;
        busy_next = busy_reg;
        op_next   = op_reg;
        if (start)
        begin
            pc_next   = A_DISP;
            busy_next = 1'b1;
            op_next   = op;
        end
        else if (fire)
        begin
            pc_next = take ? jump_to : upc_t'(pc_reg + 1'b1);
            if (uw.done)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= A_DISP;
            busy_reg <= 1'b0;
            op_reg   <= '0;
        end
        else
        begin
            pc_reg   <= pc_next;
            busy_reg <= busy_next;
            op_reg   <= op_next;
        end
    end

    assign busy   = busy_reg;
    assign ctl    = fire ? uw : UW_NOP;
    assign finish = fire && uw.done;

endmodule

[hw/rtl/modular_arithmetic_unit.sv]
// Top level of the modular arithmetic unit over p = 1000000007.
//
// Each input transaction carries an operation code in s_axis_tuser (0 add,
// 1 subtract, 2 multiply, 3 power, 4 divide; 5..7 answer 0) and the operands in
// s_axis_tdata. Operands at or above p are reduced once on entry. Divide
// multiplies the dividend by the Fermat inverse b^(p-2), so dividing by zero
// gives 0; power with a zero exponent gives 1. One item is worked at a time by
// a microcoded sequencer driving a single six-stage Barrett multiplier, and each
// item returns exactly one 30-bit residue on m_axis_tdata. Power runs a
// square-and-multiply loop over the exponent bits up to the highest set bit,
// with one more product for each set bit; divide runs the same loop over the
// 30-bit constant p-2 (15 set bits) and then one more product. Each loop step
// waits for its product to leave the multiplier, since each squaring depends on
// the one before. A finished result sits in an output register, so the next
// item is accepted while it waits for m_axis_tready.
module modular_arithmetic_unit
    import mau_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // operand_a[29:0], operand_b[59:30],
                                         // exponent[122:60], zero fill
    input  logic [2:0]   s_axis_tuser,   // operation[2:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [31:0]  m_axis_tdata    // result[29:0], zero fill
);

    logic     accept;
    logic     busy;
    logic     finish;
    logic     out_free;
    uword_t   ctl;
    dp_stat_t stat;
    logic     mul_start;
    logic     mul_done;
    resid_t   mul_x;
    resid_t   mul_y;
    resid_t   mul_res;
    resid_t   acc;

    logic     out_valid_reg, out_valid_next;
    resid_t   out_data_reg, out_data_next;

    // take a new item whenever the sequencer is free
    assign s_axis_tready = !busy;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // the output register may be refilled in the cycle it drains
    assign out_free = !out_valid_reg || m_axis_tready;

    mau_seq u_seq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .op       (s_axis_tuser),
        .stat     (stat),
        .mul_done (mul_done),
        .out_free (out_free),
        .busy     (busy),
        .ctl      (ctl),
        .finish   (finish)
    );

    mau_dp u_dp
    (
        .clk       (clk),
        .load      (accept),
        .a_in      (s_axis_tdata[29:0]),
        .b_in      (s_axis_tdata[59:30]),
        .e_in      (s_axis_tdata[122:60]),
        .ctl       (ctl),
        .mul_res   (mul_res),
        .stat      (stat),
        .mul_start (mul_start),
        .mul_x     (mul_x),
        .mul_y     (mul_y),
        .acc       (acc)
    );

    mau_modmul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .x     (mul_x),
        .y     (mul_y),
        .done  (mul_done),
        .res   (mul_res)
    );

    // Hold the result until the downstream side takes it
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (finish)
        begin
            out_valid_next = 1'b1;
            out_data_next  = acc;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_data_reg};

endmodule

[hw/rtl/mau_checker.sv]
// Port-level checks for the modular arithmetic unit, bound to the top level.
module mau_checker
    import mau_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [31:0]  m_axis_tdata
);

    // every delivered result is a reduced residue with clear fill bits
    a_result_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[29:0] < P_MOD) && (m_axis_tdata[31:30] == 2'b00))
        else $error("result not reduced below p");

    // one item at a time: ready drops right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second item accepted while one is in work");

    // a fresh result never appears the cycle after an accept
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tvalid && s_axis_tready))
        else $error("result appeared too soon after accept");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed or dropped");

endmodule

bind modular_arithmetic_unit mau_checker u_mau_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
